/* hw/rtl/sit_pkg.sv */
// shared constants, types and helpers for the signed integer to radix text unit
package sit_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int RADIX_BITS  = 6;
  localparam int CHAR_BITS   = 8;

  // restoring divider: bits retired per cycle and cycles per digit
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CYCLES  = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QBITS       = DIV_CYCLES * DIV_STEPS;
  localparam int STEP_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // digit stack holds at most one digit per value bit
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int SIDX_BITS   = $clog2(STACK_DEPTH);
  localparam int NDIG_BITS   = $clog2(STACK_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_BITS-1:0] MIN_RADIX   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] MAX_RADIX   = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] DIGIT_LIMIT = RADIX_BITS'(10);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_BITS-1:0] radix;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < DIGIT_LIMIT) begin
      c = CHAR_ZERO + CHAR_BITS'(d);
    end else begin
      c = CHAR_UPPER + CHAR_BITS'(d - DIGIT_LIMIT);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/sit_in_if.sv */
// input channel: signed value and radix
interface sit_in_if import sit_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic        [RADIX_BITS-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

/* hw/rtl/sit_out_if.sv */
// result channel: one ascii character per beat with a last flag
interface sit_out_if import sit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* hw/rtl/sit_front.sv */
// front end: takes input beats, splits sign and magnitude, clamps the radix
module sit_front import sit_pkg::*; (
  sit_in_if.sink in_if,
  output logic   push_valid,
  input  logic   push_ready,
  output job_t   push_data
);

  logic                  neg;
  logic [VALUE_BITS-1:0] raw;

  assign raw = in_if.value;
  assign neg = raw[VALUE_BITS-1];

  assign in_if.ready = push_ready;
  assign push_valid  = in_if.valid;

  always_comb begin
    push_data.neg = neg;
    // unsigned magnitude, so the most negative value comes out right
    push_data.mag = neg ? (~raw + VALUE_BITS'(1)) : raw;
    if (in_if.radix < MIN_RADIX) begin
      push_data.radix = MIN_RADIX;
    end else if (in_if.radix > MAX_RADIX) begin
      push_data.radix = MAX_RADIX;
    end else begin
      push_data.radix = in_if.radix;
    end
  end

endmodule

/* hw/rtl/sit_queue.sv */
// short job queue between front end and conversion engine
module sit_queue import sit_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic                 push;
  logic                 pop;

  assign push_ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/sit_back.sv */
// conversion engine: repeated division by the radix, digit stack, character output
module sit_back import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  job_t      pop_data,
  sit_out_if.source out_if
);

  back_state_t           state_r;
  back_state_t           state_nxt;

  logic [QBITS-1:0]      quo_r;
  logic [RADIX_BITS-1:0] rem_r;
  logic [RADIX_BITS-1:0] radix_r;
  logic [STEP_BITS-1:0]  step_r;
  logic                  neg_r;
  logic [NDIG_BITS-1:0]  ndig_r;
  logic [RADIX_BITS-1:0] stack_r [STACK_DEPTH];

  logic                  out_valid_r;
  logic [CHAR_BITS-1:0]  out_char_r;
  logic                  out_last_r;

  logic [QBITS-1:0]      quo_step;
  logic [RADIX_BITS-1:0] rem_step;
  logic                  last_step;
  logic                  digit_done;
  logic                  slot_free;
  logic                  load_sign;
  logic                  load_digit;
  logic                  take_job;
  logic [NDIG_BITS-1:0]  top_idx;

  // eight restoring steps per cycle on the running remainder
  always_comb begin
    logic [QBITS-1:0]      q;
    logic [RADIX_BITS:0]   t;
    logic [RADIX_BITS-1:0] r;
    q = quo_r;
    r = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, q[QBITS-1]};
      q = {q[QBITS-2:0], 1'b0};
      if (t >= {1'b0, radix_r}) begin
        t    = t - {1'b0, radix_r};
        q[0] = 1'b1;
      end
      r = t[RADIX_BITS-1:0];
    end
    quo_step = q;
    rem_step = r;
  end

  assign last_step  = (step_r == STEP_BITS'(DIV_CYCLES - 1));
  assign digit_done = (state_r == ST_DIV) && last_step;
  assign slot_free  = !out_valid_r || out_if.ready;
  assign top_idx    = ndig_r - NDIG_BITS'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (last_step && quo_step == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && ndig_r == NDIG_BITS'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_ready  = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_r)
      ST_IDLE: pop_ready  = 1'b1;
      ST_DIV:  ;
      ST_SIGN: load_sign  = slot_free;
      ST_EMIT: load_digit = slot_free;
      default: ;
    endcase
  end

  assign take_job = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ndig_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_sign || load_digit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take_job) begin
        ndig_r <= '0;
      end else if (digit_done) begin
        ndig_r <= ndig_r + NDIG_BITS'(1);
      end else if (load_digit) begin
        ndig_r <= top_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      quo_r   <= QBITS'(pop_data.mag);
      rem_r   <= '0;
      step_r  <= '0;
      radix_r <= pop_data.radix;
      neg_r   <= pop_data.neg;
    end else if (state_r == ST_DIV) begin
      if (last_step) begin
        // quotient becomes the next dividend, remainder restarts
        quo_r  <= quo_step;
        rem_r  <= '0;
        step_r <= '0;
      end else begin
        quo_r  <= quo_step;
        rem_r  <= rem_step;
        step_r <= step_r + STEP_BITS'(1);
      end
    end
    if (digit_done) begin
      stack_r[ndig_r[SIDX_BITS-1:0]] <= rem_step;
    end
    if (load_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (load_digit) begin
      out_char_r <= digit_char(stack_r[top_idx[SIDX_BITS-1:0]]);
      out_last_r <= (ndig_r == NDIG_BITS'(1));
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.character = out_char_r;
  assign out_if.last      = out_last_r;

endmodule

/* hw/rtl/signed_integer_to_radix_text_unit.sv */
// top level of the signed integer to radix text unit
//
//   channel  dir  beat contents
//   in_if    in   value (signed 32 bits), radix (6 bits, clamped to 2..36)
//   out_if   out  character (8-bit ascii), last (end of one number's text)
//
// each digit comes from restoring division by the radix (8 quotient bits per cycle
// over a 32-bit dividend); the characters then follow, with a leading '-'
// when negative, and the engine then returns to idle to take the next job.
// the front end and a two-entry job queue keep taking input beats while the
// engine works; the output register lets the engine load a new character in the
// same cycle the previous one is taken. reset is synchronous, active low.
module signed_integer_to_radix_text_unit import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_if,
  sit_out_if.source out_if
);

  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  sit_front u_front (
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_if    (out_if)
  );

endmodule

/* tb/tb_signed_integer_to_radix_text_unit.sv */
// testbench for the signed integer to radix text unit: directed and random numbers checked
// character by character against a text predictor
module tb_signed_integer_to_radix_text_unit;
  import sit_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
  } text_beat_t;

  class number_text_scoreboard;
    text_beat_t expected_text[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // expected characters of one accepted number, sign first, most significant digit next
    function void note_number(logic signed [VALUE_BITS-1:0] value,
                              logic [RADIX_BITS-1:0] radix);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] base;
      logic [VALUE_BITS-1:0] rem;
      logic [CHAR_BITS-1:0]  digits[$];
      text_beat_t            beat;
      bit                    neg;
      neg = value[VALUE_BITS-1];
      mag = neg ? -value : value;
      if (radix < MIN_RADIX) begin
        base = VALUE_BITS'(MIN_RADIX);
      end else if (radix > MAX_RADIX) begin
        base = VALUE_BITS'(MAX_RADIX);
      end else begin
        base = VALUE_BITS'(radix);
      end
      do begin
        rem = mag % base;
        if (rem < VALUE_BITS'(DIGIT_LIMIT)) begin
          digits.push_front(CHAR_ZERO + CHAR_BITS'(rem));
        end else begin
          digits.push_front(CHAR_UPPER + CHAR_BITS'(rem - VALUE_BITS'(DIGIT_LIMIT)));
        end
        mag = mag / base;
      end while (mag != 0);
      if (neg) begin
        beat.character = CHAR_MINUS;
        beat.last = 1'b0;
        expected_text.push_back(beat);
      end
      foreach (digits[i]) begin
        beat.character = digits[i];
        beat.last = (i == digits.size() - 1);
        expected_text.push_back(beat);
      end
    endfunction

    task check_char(logic [CHAR_BITS-1:0] character, logic last);
      text_beat_t want;
      if (expected_text.size() == 0) begin
        report($sformatf("char %h last %b with nothing expected", character, last));
      end else begin
        want = expected_text.pop_front();
        if (character !== want.character)
          report($sformatf("char got %h expected %h", character, want.character));
        if (last !== want.last)
          report($sformatf("last got %b expected %b on char %h", last, want.last,
                           want.character));
      end
    endtask

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_toggle;
  bit   hold_seen;
  int   hold_left;
  int   cycle_count;
  number_text_scoreboard sb;

  sit_in_if  in_ch ();
  sit_out_if out_ch ();

  signed_integer_to_radix_text_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_toggle = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    sb = new();
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check accepted beats, drive ready with random stalls or a long hold
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_char(out_ch.character, out_ch.last);
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task send_number(logic signed [VALUE_BITS-1:0] value, logic [RADIX_BITS-1:0] radix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.radix <= radix;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_number(value, radix);
  endtask

  task wait_text_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $signed(VALUE_BITS'($urandom_range(80))) - 40;
      2: v = $urandom_range(1) ? MOST_POS - $urandom_range(3) : MOST_NEG + $urandom_range(3);
      3: begin
        v = $urandom_range(100000);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_BITS-1:0] pick_radix();
    // mostly legal bases, sometimes out of range to hit the clamps
    if ($urandom_range(9) == 0) return RADIX_BITS'($urandom_range(63));
    return RADIX_BITS'($urandom_range(36, 2));
  endfunction

  task run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_number(pick_value(), pick_radix());
    wait_text_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, sign handling, most negative, clamped radix, letter digits
    send_number(0, 10);
    send_number(0, 2);
    send_number(0, 63);
    send_number(1, 10);
    send_number(-1, 10);
    send_number(9, 10);
    send_number(10, 11);
    send_number(35, 36);
    send_number(-36, 36);
    send_number(MOST_POS, 2);
    send_number(MOST_POS, 36);
    send_number(MOST_POS, 10);
    send_number(MOST_NEG, 16);
    send_number(MOST_NEG, 2);
    send_number(MOST_NEG, 36);
    send_number(MOST_NEG + 1, 10);
    send_number(5, 0);
    send_number(-5, 1);
    send_number(1295, 37);
    send_number(-1296, 63);
    send_number(32'h5555_5555, 2);
    send_number(32'h2AAA_AAAA, 3);
    wait_text_drained();

    run_phase(120, 0, 0);
    run_phase(110, 85, 0);
    run_phase(110, 0, 85);
    run_phase(110, 38, 38);

    // long hold on the result side while the sender keeps offering beats
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_toggle <= ~hold_toggle;
    repeat (30) send_number(pick_value(), pick_radix());
    wait_text_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d characters never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
